// File: rtl/rde_pkg.sv
// shared types, constants and command/status structs of the raster draw engine
// used by every module of the block; depends on nothing

package rde_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int DEF_PAGES      = 2;
    localparam int DEF_MAX_RADIUS = 31;

    // field widths
    localparam int PIX_W   = 32;
    localparam int CNT_W   = 15;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     RESET_ACTIVE_SIZE = 8'd128;

    // command codes
    localparam logic [2:0] ACT_POINT  = 3'd0;
    localparam logic [2:0] ACT_HLINE  = 3'd1;
    localparam logic [2:0] ACT_VLINE  = 3'd2;
    localparam logic [2:0] ACT_RECT   = 3'd3;
    localparam logic [2:0] ACT_FILL   = 3'd4;
    localparam logic [2:0] ACT_CIRCLE = 3'd5;
    localparam logic [2:0] ACT_READ   = 3'd6;
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    // signed walk coordinates, wide enough for center minus radius and start plus length
    localparam int CW = 10;
    typedef logic signed [CW-1:0] coord_t;

    // circle arithmetic in Q8
    localparam int SQ_IN_W  = 28;
    localparam int SQ_OUT_W = 14;
    localparam int AA_FULL  = 461;   // 1.8 in Q8
    localparam int AA_EDGE  = 154;   // 0.6 in Q8
    localparam int AA_ONE   = 256;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic clr_wr;
        logic seg_load;
        logic seg_inc;
        logic pix_latch;
        logic sq_start;
        logic sq_latch;
        logic mem_rd;
        logic rd_latch;
        logic mem_wr;
        logic step;
        logic out_load;
    } rde_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic seg_empty;
        logic last_seg;
        logic last_pix;
        logic in_clip;
        logic is_circle;
        logic is_read;
        logic sq_done;
        logic sq_hit;
        logic out_free;
    } rde_stat_t;

endpackage

// File: rtl/raster_draw_engine_core.sv
// Raster draw engine: one command per transfer, one result transfer per command.
// Points, lines, rectangles and fills walk their pixels one by one; a circle pixel waits on
// the 14-step root unit before it is drawn or skipped.
// A stalled result holds the engine once its next result is ready.
// One command at a time; the next is taken the cycle after its result is registered.
// Reset: async active low; the store is then swept to zero word by word.

module raster_draw_engine_core
    import rde_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PAGES      = DEF_PAGES,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           action,
    input  logic                 page,
    input  logic [6:0]           x0,
    input  logic [6:0]           y0,
    input  logic [6:0]           x1,
    input  logic [6:0]           y1,
    input  logic [7:0]           span_len,
    input  logic [4:0]           circle_radius,
    input  logic [PIX_W-1:0]     draw_color,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIX_W-1:0]     read_pixel,
    output logic [CNT_W-1:0]     pixels_written
);

    rde_cmd_t  cmd;
    rde_stat_t stat;

    // sequencing
    rde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage and arithmetic
    rde_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PAGES      (PAGES),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .action         (action),
        .page           (page),
        .x0             (x0),
        .y0             (y0),
        .x1             (x1),
        .y1             (y1),
        .span_len       (span_len),
        .circle_radius  (circle_radius),
        .draw_color     (draw_color),
        .out_ready      (out_ready),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .read_pixel     (read_pixel),
        .pixels_written (pixels_written)
    );

endmodule

// File: rtl/rde_sqrt.sv
// iterative integer square root, one result bit per cycle
// depends on rde_pkg for operand and result widths

module rde_sqrt
    import rde_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SQ_IN_W-1:0]  operand,
    output logic                done,
    output logic [SQ_OUT_W-1:0] root
);

    localparam int ITW = $clog2(SQ_OUT_W);

    logic [SQ_IN_W-1:0]  op_reg, op_next;
    logic [SQ_OUT_W+1:0] rem_reg, rem_next;
    logic [SQ_OUT_W-1:0] root_reg, root_next;
    logic [ITW-1:0]      iter_reg, iter_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [SQ_OUT_W+1:0] rem_sh;
    logic [SQ_OUT_W+1:0] trial;
    logic                ge;

    // one restoring step: bring down two operand bits and try the next root bit
    always_comb
    begin
        rem_sh    = {rem_reg[SQ_OUT_W-1:0], op_reg[SQ_IN_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        ge        = (rem_sh >= trial);
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            op_next   = operand;
            rem_next  = '0;
            root_next = '0;
            iter_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            op_next   = {op_reg[SQ_IN_W-3:0], 2'b00};
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[SQ_OUT_W-2:0], ge};
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITW'(SQ_OUT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    // working values
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/rde_ctrl.sv
// controller state machine of the raster draw engine
// depends on rde_pkg for the command and status structs

module rde_ctrl
    import rde_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  rde_stat_t stat,
    output rde_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SEG,
        S_CHK,
        S_PIX,
        S_SQ,
        S_RD,
        S_RDL,
        S_WR,
        S_ADV,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SEG;
                end
            end
            S_SEG:
            begin
                cmd.seg_load = 1'b1;
                state_next   = S_CHK;
            end
            S_CHK:
            begin
                if (!stat.seg_empty)
                    state_next = S_PIX;
                else if (stat.last_seg)
                    state_next = S_DONE;
                else
                begin
                    cmd.seg_inc = 1'b1;
                    state_next  = S_SEG;
                end
            end
            S_PIX:
            begin
                cmd.pix_latch = 1'b1;
                if (stat.is_read)
                    state_next = stat.in_clip ? S_RD : S_DONE;
                else if (stat.is_circle)
                begin
                    cmd.sq_start = 1'b1;
                    state_next   = S_SQ;
                end
                else
                    state_next = stat.in_clip ? S_WR : S_ADV;
            end
            S_SQ:
            begin
                if (stat.sq_done)
                begin
                    cmd.sq_latch = 1'b1;
                    state_next   = stat.sq_hit ? S_RD : S_ADV;
                end
            end
            S_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = stat.is_read ? S_RDL : S_WR;
            end
            S_RDL:
            begin
                cmd.rd_latch = 1'b1;
                state_next   = S_DONE;
            end
            S_WR:
            begin
                cmd.mem_wr = 1'b1;
                state_next = S_ADV;
            end
            S_ADV:
            begin
                if (!stat.last_pix)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_PIX;
                end
                else if (stat.last_seg)
                    state_next = S_DONE;
                else
                begin
                    cmd.seg_inc = 1'b1;
                    state_next  = S_SEG;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register; the store is swept clean after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// File: rtl/rde_dp.sv
// datapath of the raster draw engine: config registers, walker, address, blend, pixel store
// depends on rde_pkg and instantiates rde_sqrt

module rde_dp
    import rde_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PAGES      = DEF_PAGES,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [2:0]           action,
    input  logic                 page,
    input  logic [6:0]           x0,
    input  logic [6:0]           y0,
    input  logic [6:0]           x1,
    input  logic [6:0]           y1,
    input  logic [7:0]           span_len,
    input  logic [4:0]           circle_radius,
    input  logic [PIX_W-1:0]     draw_color,
    input  logic                 out_ready,
    input  rde_cmd_t             cmd,
    output rde_stat_t            stat,
    output logic                 out_valid,
    output logic [PIX_W-1:0]     read_pixel,
    output logic [CNT_W-1:0]     pixels_written
);

    localparam int DEPTH = PAGES * MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    function automatic coord_t ext7(input logic [6:0] v);
        return coord_t'({{(CW-7){1'b0}}, v});
    endfunction

    function automatic coord_t ext8(input logic [7:0] v);
        return coord_t'({{(CW-8){1'b0}}, v});
    endfunction

    function automatic logic [7:0] blend8(input logic [7:0] d, input logic [7:0] s,
                                          input logic [8:0] a);
        logic [16:0] acc;
        acc = 17'(d * (9'(AA_ONE) - a)) + 17'(s * a);
        return acc[15:8];
    endfunction

    // configuration registers
    logic [CFG_W-1:0] aw_reg, ah_reg;
    logic [7:0]       w_eff, h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg <= RESET_ACTIVE_SIZE;
            ah_reg <= RESET_ACTIVE_SIZE;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_ACTIVE_WIDTH:  aw_reg <= cfg_data;
                REG_ACTIVE_HEIGHT: ah_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign w_eff = (32'(aw_reg) < MAX_WIDTH)  ? aw_reg : 8'(MAX_WIDTH);
    assign h_eff = (32'(ah_reg) < MAX_HEIGHT) ? ah_reg : 8'(MAX_HEIGHT);

    // command fields captured at input transfer
    logic [2:0]       act_reg;
    logic             page_reg;
    logic [6:0]       x0_reg, y0_reg, x1_reg, y1_reg;
    logic [7:0]       len_reg;
    logic [4:0]       r_reg;
    logic [PIX_W-1:0] color_reg;
    logic [7:0]       w_reg, h_reg;
    logic [15:0]      wh_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= action;
            page_reg  <= (PAGES > 1) ? page : 1'b0;
            x0_reg    <= x0;
            y0_reg    <= y0;
            x1_reg    <= x1;
            y1_reg    <= y1;
            len_reg   <= span_len;
            r_reg     <= (32'(circle_radius) > MAX_RADIUS) ? 5'(MAX_RADIUS) : circle_radius;
            color_reg <= draw_color;
            w_reg     <= w_eff;
            h_reg     <= h_eff;
            wh_reg    <= 16'(w_eff * h_eff);
        end
    end

    // segment selection: rectangles walk top, bottom, left and right edges as segments, every other command one span
    logic [1:0] seg_reg;
    coord_t     sxs, sxe, sys, sye;
    coord_t     cx, cy, rr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_reg <= '0;
        else if (cmd.load)
            seg_reg <= '0;
        else if (cmd.seg_inc)
            seg_reg <= seg_reg + 1'b1;
    end

    assign cx = ext7(x0_reg);
    assign cy = ext7(y0_reg);
    assign rr = coord_t'({{(CW-5){1'b0}}, r_reg});

    // span bounds of the current segment, inclusive
    always_comb
    begin
        sxs = ext7(x0_reg);
        sxe = ext7(x0_reg);
        sys = ext7(y0_reg);
        sye = ext7(y0_reg);
        case (act_reg)
            ACT_POINT, ACT_READ:
            begin
            end
            ACT_HLINE:
                sxe = ext7(x0_reg) + ext8(len_reg) - coord_t'(1);
            ACT_VLINE:
                sye = ext7(y0_reg) + ext8(len_reg) - coord_t'(1);
            ACT_RECT:
            begin
                case (seg_reg)
                    2'd0:
                        sxe = ext7(x1_reg);
                    2'd1:
                    begin
                        sxe = ext7(x1_reg);
                        sys = ext7(y1_reg);
                        sye = ext7(y1_reg);
                    end
                    2'd2:
                    begin
                        sys = ext7(y0_reg) + coord_t'(1);
                        sye = ext7(y1_reg) - coord_t'(1);
                    end
                    default:
                    begin
                        sxs = ext7(x1_reg);
                        sxe = ext7(x1_reg);
                        sys = ext7(y0_reg) + coord_t'(1);
                        sye = ext7(y1_reg) - coord_t'(1);
                    end
                endcase
            end
            ACT_FILL:
            begin
                sxe = ext7(x1_reg);
                sye = ext7(y1_reg);
            end
            ACT_CIRCLE:
            begin
                sxs = cx - rr;
                sxe = cx + rr;
                sys = cy - rr;
                sye = cy + rr;
            end
            default:
                sxe = ext7(x0_reg) - coord_t'(1);
        endcase
    end

    // pixel walker
    coord_t xs_reg, xe_reg, ys_reg, ye_reg, x_reg, y_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.seg_load)
        begin
            xs_reg <= sxs;
            xe_reg <= sxe;
            ys_reg <= sys;
            ye_reg <= sye;
            x_reg  <= sxs;
            y_reg  <= sys;
        end
        else if (cmd.step)
        begin
            if (x_reg == xe_reg)
            begin
                x_reg <= xs_reg;
                y_reg <= y_reg + coord_t'(1);
            end
            else
                x_reg <= x_reg + coord_t'(1);
        end
    end

    // clip test and word address of the current pixel
    logic          in_clip;
    logic [16:0]   addr_sum;
    logic [AW-1:0] addr_reg;
    logic          clip_reg;

    assign in_clip = !x_reg[CW-1] && !y_reg[CW-1]
                  && (x_reg < coord_t'({{(CW-8){1'b0}}, w_reg}))
                  && (y_reg < coord_t'({{(CW-8){1'b0}}, h_reg}));
    assign addr_sum = (page_reg ? 17'(wh_reg) : 17'd0)
                    + 17'(y_reg[7:0] * w_reg) + 17'(x_reg[7:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.pix_latch)
        begin
            addr_reg <= AW'(addr_sum);
            clip_reg <= in_clip;
        end
    end

    // squared distance from the center into the root unit
    coord_t              dx, dy;
    logic [4:0]          adx, ady;
    logic [10:0]         d2;
    logic [SQ_OUT_W-1:0] root_q;
    logic                sq_done;

    assign dx  = x_reg - cx;
    assign dy  = y_reg - cy;
    assign adx = dx[CW-1] ? 5'(-dx) : 5'(dx);
    assign ady = dy[CW-1] ? 5'(-dy) : 5'(dy);
    assign d2  = 11'(adx * adx) + 11'(ady * ady);

    rde_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.sq_start),
        .operand (SQ_IN_W'({d2, 16'h0000})),
        .done    (sq_done),
        .root    (root_q)
    );

    // coverage weight from the distance to the rim
    logic [16:0]        rq, dist17;
    logic               rim_hit;
    logic signed [17:0] diff, adiff, aval;
    logic [8:0]         a_comb, a_reg;

    assign rq      = 17'({r_reg, 8'h00});
    assign dist17  = 17'(root_q);
    assign rim_hit = dist17 <= (rq + 17'(AA_EDGE));
    assign diff    = $signed({1'b0, dist17}) - $signed({1'b0, rq});
    assign adiff   = diff[17] ? -diff : diff;
    assign aval    = 18'(AA_FULL) - adiff;

    always_comb
    begin
        if (aval[17])
            a_comb = '0;
        else if (aval > 18'(AA_ONE))
            a_comb = 9'(AA_ONE);
        else
            a_comb = aval[8:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sq_latch)
            a_reg <= a_comb;
    end

    // pixel store with a clearing sweep after reset
    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] mem_q;
    logic [AW-1:0]    clr_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [PIX_W-1:0] mem_wdata, draw_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_wr)
            clr_reg <= clr_reg + 1'b1;
    end

    assign draw_data = (act_reg == ACT_CIRCLE)
                     ? {8'h00,
                        blend8(mem_q[23:16], color_reg[23:16], a_reg),
                        blend8(mem_q[15:8],  color_reg[15:8],  a_reg),
                        blend8(mem_q[7:0],   color_reg[7:0],   a_reg)}
                     : color_reg;
    assign mem_we    = cmd.clr_wr || cmd.mem_wr;
    assign mem_waddr = cmd.clr_wr ? clr_reg : addr_reg;
    assign mem_wdata = cmd.clr_wr ? '0 : draw_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.mem_rd)
            mem_q <= mem[addr_reg];
    end

    // result accumulation and output register
    logic [CNT_W-1:0] cnt_reg;
    logic [PIX_W-1:0] rd_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] read_pixel_reg;
    logic [CNT_W-1:0] pixels_written_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end
        else
        begin
            if (cmd.mem_wr)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.rd_latch)
                rd_reg <= mem_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            read_pixel_reg     <= rd_reg;
            pixels_written_reg <= cnt_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_pixel     = read_pixel_reg;
    assign pixels_written = pixels_written_reg;

    // status back to the controller
    always_comb
    begin
        stat.clr_last  = (clr_reg == AW'(DEPTH - 1));
        stat.seg_empty = (xe_reg < xs_reg) || (ye_reg < ys_reg);
        stat.last_seg  = (act_reg != ACT_RECT) || (seg_reg == 2'd3);
        stat.last_pix  = (x_reg == xe_reg) && (y_reg == ye_reg);
        stat.in_clip   = in_clip;
        stat.is_circle = (act_reg == ACT_CIRCLE);
        stat.is_read   = (act_reg == ACT_READ);
        stat.sq_done   = sq_done;
        stat.sq_hit    = rim_hit && clip_reg;
        stat.out_free  = !out_valid_reg || out_ready;
    end

endmodule

// File: rtl/rde_checker.sv
// port-level checks of the raster draw engine, bound to the top level
// depends on rde_pkg for widths

module rde_checker
    import rde_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [PIX_W-1:0]     read_pixel,
    input logic [CNT_W-1:0]     pixels_written
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_pixel)
            && $stable(pixels_written))
        else $error("result changed while stalled");

    // one command in flight: busy right after an input transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a command is in flight");

    // a result never carries both read data and a write count
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (read_pixel == '0) || (pixels_written == '0))
        else $error("read data and write count both set");

    // write count bounded by one full page
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pixels_written <= CNT_W'(16384))
        else $error("write count above one full page");

endmodule

bind raster_draw_engine_core rde_checker u_rde_checker (.*);

// File: tb/sv/tb.sv
// self-checking testbench of raster_draw_engine_core: commands in, pixel counts and reads out
// depends on rde_pkg and raster_draw_engine_core; keeps its own shadow of the two pixel pages

module tb;
    import rde_pkg::*;

    localparam int  STORE_DEPTH = DEF_PAGES * DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam longint CYCLE_LIMIT = 6_000_000;

    typedef struct {
        logic [2:0]       action;
        logic             page;
        logic [6:0]       x0;
        logic [6:0]       y0;
        logic [6:0]       x1;
        logic [6:0]       y1;
        logic [7:0]       span_len;
        logic [4:0]       circle_radius;
        logic [PIX_W-1:0] draw_color;
    } draw_cmd_t;

    typedef struct {
        logic [PIX_W-1:0] read_pixel;
        logic [CNT_W-1:0] pixels_written;
    } draw_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [2:0]       action = '0;
    logic             page = 1'b0;
    logic [6:0]       x0 = '0;
    logic [6:0]       y0 = '0;
    logic [6:0]       x1 = '0;
    logic [6:0]       y1 = '0;
    logic [7:0]       span_len = '0;
    logic [4:0]       circle_radius = '0;
    logic [PIX_W-1:0] draw_color = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [PIX_W-1:0] read_pixel;
    logic [CNT_W-1:0] pixels_written;

    // shadow state
    bit [PIX_W-1:0]   shadow_pix [STORE_DEPTH];
    int unsigned      shadow_w = RESET_ACTIVE_SIZE;
    int unsigned      shadow_h = RESET_ACTIVE_SIZE;

    draw_cmd_t        cmd_queue[$];
    draw_result_t     expected_results[$];
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    int               error_count = 0;
    longint           cycle_count = 0;

    raster_draw_engine_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .page           (page),
        .x0             (x0),
        .y0             (y0),
        .x1             (x1),
        .y1             (y1),
        .span_len       (span_len),
        .circle_radius  (circle_radius),
        .draw_color     (draw_color),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_pixel     (read_pixel),
        .pixels_written (pixels_written)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // word index of a pixel in the shadow store, -1 when clipped
    function automatic int pixel_index(input logic pg, input int px, input int py);
        int w;
        int h;
        begin
            w = (shadow_w < DEF_MAX_WIDTH) ? shadow_w : DEF_MAX_WIDTH;
            h = (shadow_h < DEF_MAX_HEIGHT) ? shadow_h : DEF_MAX_HEIGHT;
            if (px < 0 || py < 0 || px >= w || py >= h)
                return -1;
            return int'(pg) * w * h + py * w + px;
        end
    endfunction

    function automatic int plot(input logic pg, input int px, input int py,
                                input logic [PIX_W-1:0] color);
        int idx;
        begin
            idx = pixel_index(pg, px, py);
            if (idx < 0)
                return 0;
            shadow_pix[idx] = color;
            return 1;
        end
    endfunction

    function automatic int run_line(input logic pg, input int px, input int py,
                                    input bit horiz, input int len,
                                    input logic [PIX_W-1:0] color);
        int n;
        begin
            n = 0;
            for (int i = 0; i < len; i++)
                n += horiz ? plot(pg, px + i, py, color) : plot(pg, px, py + i, color);
            return n;
        end
    endfunction

    // floor square root, bit by bit from the top
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        begin
            r = 0;
            for (int b = 20; b >= 0; b--)
            begin
                t = r | (longint'(1) << b);
                if (t * t <= v)
                    r = t;
            end
            return r;
        end
    endfunction

    function automatic int mix_channel(input int dst, input int src, input int a);
        return ((dst * (256 - a) + src * a) >> 8) & 8'hFF;
    endfunction

    // antialiased circle on the shadow store
    function automatic int run_circle(input logic pg, input int cx, input int cy, input int r,
                                      input logic [PIX_W-1:0] color);
        int n;
        int idx;
        longint root_dist;
        longint diff;
        int a;
        logic [PIX_W-1:0] d;
        begin
            n = 0;
            for (int dy = -r; dy <= r; dy++)
            begin
                for (int dx = -r; dx <= r; dx++)
                begin
                    root_dist = longint'(floor_root(longint'(dx * dx + dy * dy) << 16));
                    if (root_dist > r * 256 + AA_EDGE)
                        continue;
                    idx = pixel_index(pg, cx + dx, cy + dy);
                    if (idx < 0)
                        continue;
                    diff = root_dist - r * 256;
                    if (diff < 0)
                        diff = -diff;
                    a = AA_FULL - int'(diff);
                    if (a < 0)
                        a = 0;
                    if (a > AA_ONE)
                        a = AA_ONE;
                    d = shadow_pix[idx];
                    shadow_pix[idx] = {8'h00,
                        8'(mix_channel(d[23:16], color[23:16], a)),
                        8'(mix_channel(d[15:8], color[15:8], a)),
                        8'(mix_channel(d[7:0], color[7:0], a))};
                    n++;
                end
            end
            return n;
        end
    endfunction

    // apply one command to the shadow store and give its result
    function automatic draw_result_t apply_draw(input draw_cmd_t c);
        draw_result_t res;
        int n;
        int idx;
        int ix0;
        int iy0;
        int ix1;
        int iy1;
        begin
            n = 0;
            res.read_pixel = '0;
            ix0 = c.x0;
            iy0 = c.y0;
            ix1 = c.x1;
            iy1 = c.y1;
            case (c.action)
                ACT_POINT:  n = plot(c.page, ix0, iy0, c.draw_color);
                ACT_HLINE:  n = run_line(c.page, ix0, iy0, 1'b1, c.span_len, c.draw_color);
                ACT_VLINE:  n = run_line(c.page, ix0, iy0, 1'b0, c.span_len, c.draw_color);
                ACT_RECT:
                begin
                    n += run_line(c.page, ix0, iy0, 1'b1, ix1 - ix0 + 1, c.draw_color);
                    n += run_line(c.page, ix0, iy1, 1'b1, ix1 - ix0 + 1, c.draw_color);
                    n += run_line(c.page, ix0, iy0 + 1, 1'b0, iy1 - iy0 - 1, c.draw_color);
                    n += run_line(c.page, ix1, iy0 + 1, 1'b0, iy1 - iy0 - 1, c.draw_color);
                end
                ACT_FILL:
                begin
                    for (int yy = iy0; yy <= iy1; yy++)
                        for (int xx = ix0; xx <= ix1; xx++)
                            n += plot(c.page, xx, yy, c.draw_color);
                end
                ACT_CIRCLE:
                    n = run_circle(c.page, ix0, iy0,
                                   (c.circle_radius > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS
                                                                      : c.circle_radius,
                                   c.draw_color);
                ACT_READ:
                begin
                    idx = pixel_index(c.page, ix0, iy0);
                    if (idx >= 0)
                        res.read_pixel = shadow_pix[idx];
                end
                default: ;
            endcase
            res.pixels_written = CNT_W'(n);
            return res;
        end
    endfunction

    function automatic draw_cmd_t make_cmd(input logic [2:0] act, input logic pg,
                                           input int ax0, input int ay0,
                                           input int ax1, input int ay1,
                                           input int len, input int rad,
                                           input logic [PIX_W-1:0] color);
        draw_cmd_t c;
        begin
            c.action = act;
            c.page = pg;
            c.x0 = 7'(ax0);
            c.y0 = 7'(ay0);
            c.x1 = 7'(ax1);
            c.y1 = 7'(ay1);
            c.span_len = 8'(len);
            c.circle_radius = 5'(rad);
            c.draw_color = color;
            return c;
        end
    endfunction

    // random command, mostly small so the run stays short
    function automatic draw_cmd_t random_cmd();
        draw_cmd_t c;
        int sel;
        begin
            c.page = 1'($urandom_range(1));
            c.x0 = 7'($urandom_range(127));
            c.y0 = 7'($urandom_range(127));
            c.x1 = 7'($urandom_range(127));
            c.y1 = 7'($urandom_range(127));
            c.span_len = 8'($urandom_range(255));
            c.circle_radius = 5'($urandom_range(31));
            c.draw_color = $urandom;
            sel = $urandom_range(99);
            if (sel < 10)
                c.action = ACT_POINT;
            else if (sel < 20)
                c.action = ACT_HLINE;
            else if (sel < 30)
                c.action = ACT_VLINE;
            else if (sel < 40)
                c.action = ACT_RECT;
            else if (sel < 52)
                c.action = ACT_FILL;
            else if (sel < 62)
                c.action = ACT_CIRCLE;
            else if (sel < 97)
                c.action = ACT_READ;
            else
                c.action = ACT_UNUSED;
            // keep areas small except now and then
            if ((c.action == ACT_RECT || c.action == ACT_FILL) && $urandom_range(39) != 0)
            begin
                c.x1 = c.x0 + 7'($urandom_range(8)) - 7'($urandom_range(1));
                c.y1 = c.y0 + 7'($urandom_range(8)) - 7'($urandom_range(1));
            end
            if (c.action == ACT_CIRCLE && $urandom_range(29) != 0)
                c.circle_radius = 5'($urandom_range(7));
            // reads mostly inside the active area
            if (c.action == ACT_READ && $urandom_range(3) != 0)
            begin
                c.x0 = 7'($urandom_range((shadow_w > 0 && shadow_w < 128) ? shadow_w - 1 : 127));
                c.y0 = 7'($urandom_range((shadow_h > 0 && shadow_h < 128) ? shadow_h - 1 : 127));
            end
            return c;
        end
    endfunction

    // command driver; a transfer updates the shadow store at once
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(apply_draw('{action, page, x0, y0, x1, y1,
                                                        span_len, circle_radius,
                                                        draw_color}));
            if (!in_valid || in_ready)
            begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    draw_cmd_t c;
                    c = cmd_queue.pop_front();
                    action <= c.action;
                    page <= c.page;
                    x0 <= c.x0;
                    y0 <= c.y0;
                    x1 <= c.x1;
                    y1 <= c.y1;
                    span_len <= c.span_len;
                    circle_radius <= c.circle_radius;
                    draw_color <= c.draw_color;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                   input logic [PIX_W-1:0] want);
        error_count++;
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    endtask

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", read_pixel, '0);
            end
            else
            begin
                draw_result_t e;
                e = expected_results.pop_front();
                if (read_pixel !== e.read_pixel)
                    report_mismatch("read_pixel", read_pixel, e.read_pixel);
                if (pixels_written !== e.pixels_written)
                    report_mismatch("pixels_written", PIX_W'(pixels_written),
                                    PIX_W'(e.pixels_written));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_ACTIVE_WIDTH)
            shadow_w = val & 8'hFF;
        else
            shadow_h = val & 8'hFF;
    endtask

    // sender holds off until every result is back
    task automatic drain();
        do
            @(negedge clk);
        while (cmd_queue.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    int phase_w [8] = '{255, 1, 64, 0, 128, 100, 37, 128};
    int phase_h [8] = '{200, 1, 100, 128, 0, 37, 90, 128};

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // store clear after reset
        do
            @(posedge clk);
        while (!in_ready);
        write_reg(REG_ACTIVE_WIDTH, 128);
        write_reg(REG_ACTIVE_HEIGHT, 128);

        // directed commands
        cmd_queue.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_POINT, 0, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF));
        cmd_queue.push_back(make_cmd(ACT_POINT, 1, 127, 127, 127, 127, 255, 31, 32'h00A5_5A3C));
        cmd_queue.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_READ, 1, 127, 127, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_HLINE, 0, 5, 3, 0, 0, 0, 0, 32'h0011_2233));
        cmd_queue.push_back(make_cmd(ACT_HLINE, 0, 100, 4, 0, 0, 255, 0, 32'h0044_5566));
        cmd_queue.push_back(make_cmd(ACT_VLINE, 1, 0, 0, 0, 0, 128, 0, 32'h0077_8899));
        cmd_queue.push_back(make_cmd(ACT_VLINE, 1, 127, 60, 0, 0, 255, 0, 32'h00AB_CDEF));
        cmd_queue.push_back(make_cmd(ACT_RECT, 0, 10, 10, 20, 16, 0, 0, 32'h0012_3456));
        cmd_queue.push_back(make_cmd(ACT_RECT, 0, 30, 30, 30, 30, 0, 0, 32'h0065_4321));
        cmd_queue.push_back(make_cmd(ACT_RECT, 0, 40, 40, 35, 41, 0, 0, 32'h0000_FF00));
        cmd_queue.push_back(make_cmd(ACT_RECT, 1, 120, 120, 127, 127, 0, 0, 32'h00FF_0000));
        cmd_queue.push_back(make_cmd(ACT_FILL, 0, 50, 50, 54, 53, 0, 0, 32'h0080_8080));
        cmd_queue.push_back(make_cmd(ACT_FILL, 0, 60, 60, 59, 62, 0, 0, 32'h0001_0203));
        cmd_queue.push_back(make_cmd(ACT_FILL, 1, 0, 0, 127, 127, 0, 0, 32'h0020_4060));
        cmd_queue.push_back(make_cmd(ACT_CIRCLE, 0, 64, 64, 0, 0, 0, 0, 32'h00FF_FFFF));
        cmd_queue.push_back(make_cmd(ACT_CIRCLE, 0, 52, 51, 0, 0, 0, 5, 32'hFFFF_0000));
        cmd_queue.push_back(make_cmd(ACT_CIRCLE, 1, 2, 125, 0, 0, 0, 31, 32'h0000_00FF));
        cmd_queue.push_back(make_cmd(ACT_READ, 0, 52, 51, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_READ, 1, 3, 124, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_UNUSED, 1, 127, 127, 127, 127, 255, 31, 32'hFFFFFFFF));
        drain();

        // random phases, each with its own size; the idling settings repeat every four phases
        for (int p = 0; p < 8; p++)
        begin
            write_reg(REG_ACTIVE_WIDTH, phase_w[p]);
            write_reg(REG_ACTIVE_HEIGHT, phase_h[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (int i = 0; i < 70; i++)
                cmd_queue.push_back(random_cmd());
            drain();
        end

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/rde_pkg.sv
rtl/rde_sqrt.sv
rtl/rde_ctrl.sv
rtl/rde_dp.sv
rtl/raster_draw_engine_core.sv
rtl/rde_checker.sv
tb/sv/tb.sv
